// File: rtl/tbp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tbp_pkg
// Shared constants and types of the tournament branch predictor: default
// table geometry, counter limits, controller states and the command/status
// bundles between controller and datapath.
// ----------------------------------------------------------------------------
package tbp_pkg;

    // payload widths of the command port
    localparam int unsigned PC_W = 10;

    // default geometry and counter limits
    localparam int unsigned LOCAL_BITS_DEF  = 10;
    localparam int unsigned GLOBAL_BITS_DEF = 12;
    localparam int unsigned LOCAL_MAX_DEF   = 7;
    localparam int unsigned GLOBAL_MAX_DEF  = 3;
    localparam int unsigned LOCAL_INIT_DEF  = 4;
    localparam int unsigned GLOBAL_INIT_DEF = 2;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CLR  = 4'b0010,
        S_LCRD = 4'b0100,
        S_UPD  = 4'b1000
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic clr;      // write reset values at the sweep address, advance it
        logic accept;   // latch the item, read history and global tables
        logic lc_rd;    // read the local counter selected by the local history
        logic upd;      // form the result, write back on an update
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic clr_last; // sweep address is at the last table entry
    } t_dp_sts;

endpackage : tbp_pkg
`default_nettype wire

// File: rtl/tbp_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tbp_ctrl
// Controller of the predictor: runs the table clearing sweep after reset,
// then sequences each command through history read, local counter read and
// result/write-back.
// ----------------------------------------------------------------------------
module tbp_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire tbp_pkg::t_dp_sts  i_sts,
    output tbp_pkg::t_dp_cmd       o_cmd
);
    import tbp_pkg::*;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (start) n_state = S_LCRD;
            S_CLR:  if (i_sts.clr_last) n_state = S_IDLE;
            S_LCRD: n_state = S_UPD;
            S_UPD:  n_state = S_IDLE;
            default: n_state = S_CLR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != S_IDLE);

    always_comb begin
        o_cmd        = '0;
        o_cmd.clr    = (r_state == S_CLR);
        o_cmd.accept = (r_state == S_IDLE) && start;
        o_cmd.lc_rd  = (r_state == S_LCRD);
        o_cmd.upd    = (r_state == S_UPD);
    end

endmodule : tbp_ctrl
`default_nettype wire

// File: rtl/tbp_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tbp_dp
// Datapath of the predictor: local history table, local counter table,
// global and chooser counter tables, global history register, the clearing
// sweep address and the prediction and training logic.
// ----------------------------------------------------------------------------
module tbp_dp #(
    parameter int unsigned LOCAL_BITS  = tbp_pkg::LOCAL_BITS_DEF,
    parameter int unsigned GLOBAL_BITS = tbp_pkg::GLOBAL_BITS_DEF,
    parameter int unsigned LOCAL_MAX   = tbp_pkg::LOCAL_MAX_DEF,
    parameter int unsigned GLOBAL_MAX  = tbp_pkg::GLOBAL_MAX_DEF,
    parameter int unsigned LOCAL_INIT  = tbp_pkg::LOCAL_INIT_DEF,
    parameter int unsigned GLOBAL_INIT = tbp_pkg::GLOBAL_INIT_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire tbp_pkg::t_dp_cmd          i_cmd,
    output tbp_pkg::t_dp_sts               o_sts,
    input  wire logic                      i_command,
    input  wire logic [tbp_pkg::PC_W-1:0]  i_pc_low,
    input  wire logic                      i_taken,
    output logic                           o_valid,
    output logic                           o_prediction,
    output logic                           o_used_global
);
    import tbp_pkg::*;

    localparam int unsigned LB    = LOCAL_BITS;
    localparam int unsigned GB    = GLOBAL_BITS;
    localparam int unsigned LTOP  = (LOCAL_MAX > LOCAL_INIT) ? LOCAL_MAX : LOCAL_INIT;
    localparam int unsigned GTOP  = (GLOBAL_MAX > GLOBAL_INIT) ? GLOBAL_MAX : GLOBAL_INIT;
    localparam int unsigned LCW   = $clog2(LTOP + 1);
    localparam int unsigned GCW   = $clog2(GTOP + 1);
    localparam int unsigned CLRW  = (LB > GB) ? LB : GB;
    localparam int unsigned PCX   = (LB > PC_W) ? LB : PC_W;
    localparam int unsigned LSIZE = 1 << LB;
    localparam int unsigned GSIZE = 1 << GB;

    localparam logic [LCW-1:0] L_MAX  = LCW'(LOCAL_MAX);
    localparam logic [LCW-1:0] L_HALF = LCW'(LOCAL_MAX / 2);
    localparam logic [LCW-1:0] L_INIT = LCW'(LOCAL_INIT);
    localparam logic [GCW-1:0] G_MAX  = GCW'(GLOBAL_MAX);
    localparam logic [GCW-1:0] G_HALF = GCW'(GLOBAL_MAX / 2);
    localparam logic [GCW-1:0] G_INIT = GCW'(GLOBAL_INIT);

    // tables
    logic [LB-1:0]  r_lhist_mem [LSIZE];
    logic [LCW-1:0] r_lctr_mem  [LSIZE];
    logic [GCW-1:0] r_gctr_mem  [GSIZE];
    logic [GCW-1:0] r_chs_mem   [GSIZE];

    // control and payload registers
    logic [CLRW-1:0] r_clr_idx;
    logic [GB-1:0]   r_ghr;
    logic            r_cmd;
    logic            r_taken;
    logic [LB-1:0]   r_pc_idx;
    logic [LB-1:0]   r_lh_q;
    logic [LCW-1:0]  r_lc_q;
    logic [GCW-1:0]  r_gc_q;
    logic [GCW-1:0]  r_cc_q;
    logic            r_valid;
    logic            r_pred;
    logic            r_used;

    logic [PCX-1:0]  pc_ext;
    logic [LB-1:0]   pc_idx;
    logic [LB-1:0]   clr_l;
    logic [GB-1:0]   clr_g;
    logic            wr_upd;
    logic            l_guess;
    logic            g_guess;
    logic            disagree;
    logic            pick_g;
    logic [LCW-1:0]  lc_next;
    logic [GCW-1:0]  gc_next;
    logic [GCW-1:0]  cc_next;

    assign pc_ext = PCX'(i_pc_low);
    assign pc_idx = pc_ext[LB-1:0];
    assign clr_l  = r_clr_idx[LB-1:0];
    assign clr_g  = r_clr_idx[GB-1:0];
    assign wr_upd = i_cmd.upd && r_cmd;

    assign o_sts.clr_last = &r_clr_idx;

    // prediction from the values read before any write-back
    assign l_guess  = (r_lc_q > L_HALF);
    assign g_guess  = (r_gc_q > G_HALF);
    assign disagree = (l_guess != g_guess);
    assign pick_g   = disagree && (r_cc_q > G_HALF);

    always_comb begin
        if (r_taken) begin
            lc_next = (r_lc_q < L_MAX) ? LCW'(r_lc_q + 1'b1) : r_lc_q;
            gc_next = (r_gc_q < G_MAX) ? GCW'(r_gc_q + 1'b1) : r_gc_q;
        end else begin
            lc_next = (r_lc_q != '0) ? LCW'(r_lc_q - 1'b1) : r_lc_q;
            gc_next = (r_gc_q != '0) ? GCW'(r_gc_q - 1'b1) : r_gc_q;
        end
        // move the chooser toward whichever guess was right
        if (l_guess == r_taken) begin
            cc_next = (r_cc_q != '0) ? GCW'(r_cc_q - 1'b1) : r_cc_q;
        end else begin
            cc_next = (r_cc_q < G_MAX) ? GCW'(r_cc_q + 1'b1) : r_cc_q;
        end
    end

    // local history table
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr) begin
            r_lhist_mem[clr_l] <= '0;
        end else if (wr_upd) begin
            r_lhist_mem[r_pc_idx] <= {r_lh_q[LB-2:0], r_taken};
        end
        if (i_cmd.accept) begin
            r_lh_q <= r_lhist_mem[pc_idx];
        end
    end

    // local counter table
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr) begin
            r_lctr_mem[clr_l] <= L_INIT;
        end else if (wr_upd) begin
            r_lctr_mem[r_lh_q] <= lc_next;
        end
        if (i_cmd.lc_rd) begin
            r_lc_q <= r_lctr_mem[r_lh_q];
        end
    end

    // global counter table
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr) begin
            r_gctr_mem[clr_g] <= G_INIT;
        end else if (wr_upd) begin
            r_gctr_mem[r_ghr] <= gc_next;
        end
        if (i_cmd.accept) begin
            r_gc_q <= r_gctr_mem[r_ghr];
        end
    end

    // chooser table, trained only when the guesses disagree
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr) begin
            r_chs_mem[clr_g] <= G_INIT;
        end else if (wr_upd && disagree) begin
            r_chs_mem[r_ghr] <= cc_next;
        end
        if (i_cmd.accept) begin
            r_cc_q <= r_chs_mem[r_ghr];
        end
    end

    // item payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_cmd    <= i_command;
            r_taken  <= i_taken;
            r_pc_idx <= pc_idx;
        end
        if (i_cmd.upd) begin
            r_pred <= pick_g ? g_guess : l_guess;
            r_used <= pick_g;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx <= '0;
            r_ghr     <= '0;
            r_valid   <= 1'b0;
        end else begin
            if (i_cmd.clr) begin
                r_clr_idx <= CLRW'(r_clr_idx + 1'b1);
            end
            if (wr_upd) begin
                r_ghr <= {r_ghr[GB-2:0], r_taken};
            end
            r_valid <= i_cmd.upd;
        end
    end

    assign o_valid       = r_valid;
    assign o_prediction  = r_pred;
    assign o_used_global = r_used;

    // global history moves only on an update write-back
    a_ghr_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$past(wr_upd)) |-> $stable(r_ghr))
        else $error("global history changed without an update");

    // a local counter read is always followed by the result stage
    a_upd_after_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.lc_rd |=> i_cmd.upd)
        else $error("local counter read not followed by result stage");

    // table sweep and item traffic never overlap
    a_clr_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clr |-> !(i_cmd.accept || i_cmd.lc_rd || i_cmd.upd))
        else $error("clearing sweep overlaps an item");

endmodule : tbp_dp
`default_nettype wire

// File: rtl/tournament_branch_predictor_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tournament_branch_predictor_unit
// Tournament branch predictor with local and global counters and a chooser.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive i_command, i_pc_low and i_taken with start high;
//   the command transfers at a clock edge where start is high and busy low.
//   i_command low asks for a prediction only, high also trains the tables
//   with i_taken and shifts it into the local and global histories.
//   Result channel: o_valid is high for exactly one cycle with o_prediction
//   and o_used_global; the receiver cannot stall it, so it must take the
//   transfer in that cycle.
//   Sequence: the command transfer reads the history and global tables, the
//   local counter read state then reads the local counter table, and the
//   result state registers the result onto o_valid and writes back. busy stays
//   high until then, so no new command is taken before the write-back is done.
//   Reset: after i_rst_n is released, busy stays high while the unit sweeps
//   all tables to their initial values, one entry per cycle, through all the
//   2**max(LOCAL_BITS, GLOBAL_BITS) addresses (4096 with the default sizes).
// ----------------------------------------------------------------------------
module tournament_branch_predictor_unit #(
    parameter int unsigned LOCAL_BITS  = tbp_pkg::LOCAL_BITS_DEF,
    parameter int unsigned GLOBAL_BITS = tbp_pkg::GLOBAL_BITS_DEF,
    parameter int unsigned LOCAL_MAX   = tbp_pkg::LOCAL_MAX_DEF,
    parameter int unsigned GLOBAL_MAX  = tbp_pkg::GLOBAL_MAX_DEF,
    parameter int unsigned LOCAL_INIT  = tbp_pkg::LOCAL_INIT_DEF,
    parameter int unsigned GLOBAL_INIT = tbp_pkg::GLOBAL_INIT_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic                      i_command,
    input  wire logic [tbp_pkg::PC_W-1:0]  i_pc_low,
    input  wire logic                      i_taken,
    output logic                           o_valid,
    output logic                           o_prediction,
    output logic                           o_used_global
);
    import tbp_pkg::*;

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    tbp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_sts   (dp_sts),
        .o_cmd   (dp_cmd)
    );

    tbp_dp #(
        .LOCAL_BITS  (LOCAL_BITS),
        .GLOBAL_BITS (GLOBAL_BITS),
        .LOCAL_MAX   (LOCAL_MAX),
        .GLOBAL_MAX  (GLOBAL_MAX),
        .LOCAL_INIT  (LOCAL_INIT),
        .GLOBAL_INIT (GLOBAL_INIT)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .o_sts         (dp_sts),
        .i_command     (i_command),
        .i_pc_low      (i_pc_low),
        .i_taken       (i_taken),
        .o_valid       (o_valid),
        .o_prediction  (o_prediction),
        .o_used_global (o_used_global)
    );

    // every transfer in gives exactly one result
    a_accept_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##3 o_valid)
        else $error("accepted command produced no result");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("unit took a command without going busy");

    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy && !$past(o_valid))
        else $error("result strobe while busy or held for two cycles");

endmodule : tournament_branch_predictor_unit
`default_nettype wire

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the tournament branch predictor. A scoreboard
// class keeps its own copy of the history tables, local, global and chooser
// counters, and works out the prediction for every command transfer. Each
// strobed result is compared with the oldest expected guess. Stimulus is a
// short directed run of saturating and alternating branches, then
// loop-shaped branch streams on a few hot PCs mixed with random PCs, under
// three sender idle profiles.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int unsigned LB       = tbp_pkg::LOCAL_BITS_DEF;
    localparam int unsigned GB       = tbp_pkg::GLOBAL_BITS_DEF;
    localparam int unsigned L_SIZE   = 1 << LB;
    localparam int unsigned G_SIZE   = 1 << GB;
    localparam int unsigned L_MAX    = tbp_pkg::LOCAL_MAX_DEF;
    localparam int unsigned G_MAX    = tbp_pkg::GLOBAL_MAX_DEF;
    localparam int unsigned L_INIT   = tbp_pkg::LOCAL_INIT_DEF;
    localparam int unsigned G_INIT   = tbp_pkg::GLOBAL_INIT_DEF;
    localparam int unsigned PC_W     = tbp_pkg::PC_W;

    localparam bit CMD_PREDICT = 1'b0;
    localparam bit CMD_UPDATE  = 1'b1;

    localparam int unsigned HOT_PCS        = 12;
    localparam int unsigned PHASE_ITEMS    = 460;
    localparam int unsigned DRAIN_LIMIT    = 200;
    localparam int unsigned TAIL_CYCLES    = 8;
    localparam int unsigned RUN_LIMIT      = 300000;

    typedef struct packed {
        logic prediction;
        logic used_global;
    } t_guess;

    class guess_scoreboard;
        bit [LB-1:0] hist_table [L_SIZE];
        int unsigned local_ctr [L_SIZE];
        int unsigned global_ctr [G_SIZE];
        int unsigned chooser_ctr [G_SIZE];
        bit [GB-1:0] global_hist;
        t_guess      pending_guesses [$];
        int unsigned mismatches;
        int unsigned transfers;
        int unsigned updates;
        int unsigned results;
        int unsigned global_picks;

        function void clear_tables();
            for (int unsigned i = 0; i < L_SIZE; i++) begin
                hist_table[i] = '0;
                local_ctr[i]  = L_INIT;
            end
            for (int unsigned i = 0; i < G_SIZE; i++) begin
                global_ctr[i]  = G_INIT;
                chooser_ctr[i] = G_INIT;
            end
            global_hist = '0;
        endfunction

        function int unsigned step_up(int unsigned c, int unsigned lim);
            return (c < lim) ? c + 1 : c;
        endfunction

        function int unsigned step_down(int unsigned c);
            return (c > 0) ? c - 1 : c;
        endfunction

        // Guess from the tables as they stand, then train on an update.
        function void note_branch(bit cmd, bit [PC_W-1:0] pc, bit taken);
            bit [LB-1:0] hidx;
            bit [LB-1:0] lidx;
            bit [GB-1:0] gidx;
            int unsigned lc;
            int unsigned gc;
            int unsigned cc;
            bit          lguess;
            bit          gguess;
            t_guess      g;
            hidx   = pc[LB-1:0];
            lidx   = hist_table[hidx];
            gidx   = global_hist;
            lc     = local_ctr[lidx];
            gc     = global_ctr[gidx];
            cc     = chooser_ctr[gidx];
            lguess = (lc > L_MAX / 2);
            gguess = (gc > G_MAX / 2);
            g.prediction  = lguess;
            g.used_global = 1'b0;
            if (lguess != gguess && cc > G_MAX / 2) begin
                g.prediction  = gguess;
                g.used_global = 1'b1;
            end
            pending_guesses.push_back(g);
            transfers++;
            if (cmd == CMD_UPDATE) begin
                updates++;
                if (lguess != gguess)
                    chooser_ctr[gidx] = (lguess == taken) ? step_down(cc) : step_up(cc, G_MAX);
                if (taken) begin
                    local_ctr[lidx]  = step_up(lc, L_MAX);
                    global_ctr[gidx] = step_up(gc, G_MAX);
                end else begin
                    local_ctr[lidx]  = step_down(lc);
                    global_ctr[gidx] = step_down(gc);
                end
                hist_table[hidx] = {hist_table[hidx][LB-2:0], taken};
                global_hist      = {global_hist[GB-2:0], taken};
            end
        endfunction

        function void check_guess(logic pred, logic used);
            t_guess want;
            results++;
            if (pending_guesses.size() == 0) begin
                $error("result with no command waiting: prediction=%b used_global=%b",
                       pred, used);
                mismatches++;
                return;
            end
            want = pending_guesses.pop_front();
            if (want.used_global)
                global_picks++;
            if (pred !== want.prediction) begin
                $error("prediction mismatch: expected %b, actual %b", want.prediction, pred);
                mismatches++;
            end
            if (used !== want.used_global) begin
                $error("used_global mismatch: expected %b, actual %b", want.used_global, used);
                mismatches++;
            end
        endfunction
    endclass

    logic            i_clk;
    logic            i_rst_n;
    logic            start;
    logic            busy;
    logic            i_command;
    logic [PC_W-1:0] i_pc_low;
    logic            i_taken;
    logic            o_valid;
    logic            o_prediction;
    logic            o_used_global;

    guess_scoreboard sb;
    int unsigned     sender_idle_pct;
    int unsigned     cycle_count;

    tournament_branch_predictor_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_command     (i_command),
        .i_pc_low      (i_pc_low),
        .i_taken       (i_taken),
        .o_valid       (o_valid),
        .o_prediction  (o_prediction),
        .o_used_global (o_used_global)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > RUN_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // The result is on the ports for one cycle only; take it at the edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid !== 1'b0)
            sb.check_guess(o_prediction, o_used_global);
    end

    // Called at a rising edge; returns at the edge where the command transfers.
    task automatic send_branch(bit cmd, bit [PC_W-1:0] pc, bit taken);
        while ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start     <= 1'b1;
        i_command <= cmd;
        i_pc_low  <= pc;
        i_taken   <= taken;
        do @(posedge i_clk); while (busy !== 1'b0);
        sb.note_branch(cmd, pc, taken);
    endtask

    task automatic wait_drained();
        int unsigned n;
        n = 0;
        start <= 1'b0;
        while (sb.pending_guesses.size() != 0 && n < DRAIN_LIMIT) begin
            @(posedge i_clk);
            n++;
        end
    endtask

    // Hot PCs follow loop-like patterns, with some flipped outcomes, so the
    // histories and chooser train; the rest is random PCs and directions.
    task automatic run_branch_stream(int unsigned count);
        bit [PC_W-1:0] hot_pc [HOT_PCS];
        int unsigned   hot_period [HOT_PCS];
        int unsigned   hot_pos [HOT_PCS];
        int unsigned   slot;
        bit [PC_W-1:0] pc;
        bit            cmd;
        bit            taken;
        for (int unsigned k = 0; k < HOT_PCS; k++) begin
            hot_pc[k]     = PC_W'($urandom_range(L_SIZE - 1));
            hot_period[k] = $urandom_range(2, 7);
            hot_pos[k]    = 0;
        end
        repeat (count) begin
            cmd = ($urandom_range(99) < 75) ? CMD_UPDATE : CMD_PREDICT;
            if ($urandom_range(99) < 80) begin
                slot  = $urandom_range(HOT_PCS - 1);
                pc    = hot_pc[slot];
                taken = (hot_pos[slot] != hot_period[slot] - 1);
                if ($urandom_range(99) < 8)
                    taken = ~taken;
                if (cmd == CMD_UPDATE)
                    hot_pos[slot] = (hot_pos[slot] + 1) % hot_period[slot];
            end else begin
                pc    = PC_W'($urandom_range(L_SIZE - 1));
                taken = 1'($urandom_range(1));
            end
            send_branch(cmd, pc, taken);
        end
    endtask

    initial begin
        sb = new;
        sb.clear_tables();
        cycle_count     = 0;
        sender_idle_pct = 37;
        i_rst_n   <= 1'b0;
        start     <= 1'b0;
        i_command <= CMD_PREDICT;
        i_pc_low  <= '0;
        i_taken   <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Directed: predicts ignore taken, counters saturate at zero,
        // alternating branches pull the local and global guesses apart.
        send_branch(CMD_PREDICT, '0, 1'b1);
        send_branch(CMD_PREDICT, '1, 1'b0);
        repeat (6) send_branch(CMD_UPDATE, '0, 1'b0);
        repeat (8) send_branch(CMD_UPDATE, '1, 1'b1);
        repeat (3) begin
            send_branch(CMD_UPDATE, 10'h2AA, 1'b1);
            send_branch(CMD_UPDATE, 10'h155, 1'b0);
        end
        send_branch(CMD_PREDICT, 10'h2AA, 1'b0);
        send_branch(CMD_PREDICT, 10'h155, 1'b1);
        send_branch(CMD_UPDATE, '0, 1'b1);

        // Hold off until every result of the directed run is back.
        wait_drained();

        run_branch_stream(PHASE_ITEMS);
        sender_idle_pct = 85;
        run_branch_stream(PHASE_ITEMS);
        sender_idle_pct = 0;
        run_branch_stream(PHASE_ITEMS);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.pending_guesses.size() != 0) begin
            $error("%0d expected results never arrived", sb.pending_guesses.size());
            sb.mismatches += sb.pending_guesses.size();
        end

        $display("Ran %0d branch commands (%0d updates) over three sender idle profiles,",
                 sb.transfers, sb.updates);
        $display("checked %0d results, %0d of them chosen from the global guess.",
                 sb.results, sb.global_picks);
        if (sb.mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: tournament_branch_predictor_unit.f
rtl/tbp_pkg.sv
rtl/tbp_ctrl.sv
rtl/tbp_dp.sv
rtl/tournament_branch_predictor_unit.sv
tb/sv/tb_top.sv
